>>> rtl/mfdo_pkg.sv
// shared types and codes for the message fifo with drop-oldest overflow
// used by the controller, the datapath, the top level and the checker
package mfdo_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  typedef enum logic [1:0] {
    FILL_IDLE,
    FILL_ACTIVE,
    FILL_REJECT,
    FILL_EVICT
  } fill_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_READ,
    ST_POP_LOAD
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] in_byte;
    logic       end_of_message;
    logic [6:0] max_len;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
    logic       push_ok;
    logic       dropped;
    logic [6:0] pop_len;
    logic [4:0] entry_count;
    logic       is_empty;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic pop_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic pop_stream;
    logic pop_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/mfdo_chan_if.sv
// valid/ready channel carrying one item of a given payload type
// payload types come from mfdo_pkg
interface mfdo_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mfdo_ctrl.sv
// sequencing state machine for the message fifo
// depends on mfdo_pkg for the state, command and status types
module mfdo_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mfdo_pkg::sts_t sts,
  output mfdo_pkg::ctl_t ctl
);

  mfdo_pkg::state_t state;
  mfdo_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mfdo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mfdo_pkg::ST_IDLE: begin
        if (req_valid) state_next = mfdo_pkg::ST_EXEC;
      end
      mfdo_pkg::ST_EXEC: begin
        if (sts.out_free) begin
          state_next = sts.pop_stream ? mfdo_pkg::ST_POP_READ : mfdo_pkg::ST_IDLE;
        end
      end
      mfdo_pkg::ST_POP_READ: begin
        state_next = mfdo_pkg::ST_POP_LOAD;
      end
      mfdo_pkg::ST_POP_LOAD: begin
        if (sts.out_free) begin
          state_next = sts.pop_last ? mfdo_pkg::ST_IDLE : mfdo_pkg::ST_POP_READ;
        end
      end
      default: begin
        state_next = mfdo_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    ctl.take     = 1'b0;
    ctl.exec     = 1'b0;
    ctl.pop_load = 1'b0;
    case (state)
      mfdo_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        ctl.take  = req_valid;
      end
      mfdo_pkg::ST_EXEC: begin
        ctl.exec = sts.out_free;
      end
      mfdo_pkg::ST_POP_LOAD: begin
        ctl.pop_load = sts.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/mfdo_datapath.sv
// slot pool, message links, fill and pop bookkeeping and the result register
// depends on mfdo_pkg; driven by mfdo_ctrl through ctl_t and sts_t
module mfdo_datapath #(
  parameter int SLOT_COUNT = 16,
  parameter int SLOT_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  mfdo_pkg::ctl_t ctl,
  output mfdo_pkg::sts_t sts,
  input  mfdo_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output mfdo_pkg::rsp_t rsp_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LW    = $clog2(SLOT_BYTES + 1);
  localparam int CW    = $clog2(SLOT_COUNT + 1);
  localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = (LW > 7) ? LW : 7;

  // storage
  logic [7:0]    payload  [DEPTH];
  logic [LW-1:0] len_mem  [SLOT_COUNT];
  logic [SW-1:0] link_mem [SLOT_COUNT];
  logic [7:0]    pay_rd;
  logic [LW-1:0] len_rd;
  logic [SW-1:0] link_rd;

  // control state
  mfdo_pkg::req_t      item;
  logic                drop_oldest;
  logic [SLOT_COUNT-1:0] free;
  logic [SW-1:0]       head;
  logic [SW-1:0]       tail;
  logic [CW-1:0]       count;
  mfdo_pkg::fill_state_t fill_st;
  logic [SW-1:0]       fill_slot;
  logic [LW-1:0]       fill_idx;
  logic [SW-1:0]       pop_slot;
  logic [6:0]          pop_idx;
  logic [6:0]          pop_n;
  logic                out_valid;
  mfdo_pkg::rsp_t      out_q;

  // next values of one command
  logic [SLOT_COUNT-1:0] free_next;
  logic [SW-1:0]       head_next;
  logic [SW-1:0]       tail_next;
  logic [CW-1:0]       count_next;
  mfdo_pkg::fill_state_t fill_st_next;
  logic [SW-1:0]       fill_slot_next;
  logic [LW-1:0]       fill_idx_next;
  logic [LW-1:0]       len_wdata;
  mfdo_pkg::fill_state_t eff_st;
  logic [SW-1:0]       eff_slot;
  logic [LW-1:0]       eff_idx;
  logic [SW-1:0]       free_idx;
  logic                any_free;
  logic                pay_we;
  logic                len_we;
  logic                link_we;
  logic                push_ok;
  logic                push_drop;
  logic [AW-1:0]       pay_waddr;
  logic [AW-1:0]       pay_raddr;
  logic [NW-1:0]       n_wide;
  logic [6:0]          n_pop;
  logic                exec_emits;
  logic                out_load;
  mfdo_pkg::rsp_t      load_data;

  assign cfg_ready = 1'b1;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free[i]) free_idx = SW'(i);
    end
  end
  assign any_free = |free;

  always_comb begin
    free_next      = free;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    fill_st_next   = fill_st;
    fill_slot_next = fill_slot;
    fill_idx_next  = fill_idx;
    len_wdata      = '0;
    eff_st         = fill_st;
    eff_slot       = fill_slot;
    eff_idx        = fill_idx;
    pay_we         = 1'b0;
    len_we         = 1'b0;
    link_we        = 1'b0;
    push_ok        = 1'b0;
    push_drop      = 1'b0;
    case (item.command)
      mfdo_pkg::CMD_PUSH: begin
        if (fill_st == mfdo_pkg::FILL_IDLE) begin
          eff_idx = '0;
          if (any_free) begin
            eff_st   = mfdo_pkg::FILL_ACTIVE;
            eff_slot = free_idx;
          end else if (drop_oldest && count != '0) begin
            // evict the head message and reuse its slot
            eff_st   = mfdo_pkg::FILL_EVICT;
            eff_slot = head;
            if (count > CW'(1)) head_next = link_rd;
            count_next      = count - CW'(1);
            free_next[head] = 1'b1;
          end else begin
            eff_st   = mfdo_pkg::FILL_REJECT;
            eff_slot = '0;
          end
        end
        fill_idx_next = eff_idx;
        if (eff_st != mfdo_pkg::FILL_REJECT && eff_idx < LW'(SLOT_BYTES)) begin
          pay_we        = 1'b1;
          fill_idx_next = eff_idx + LW'(1);
        end
        fill_st_next   = eff_st;
        fill_slot_next = eff_slot;
        if (item.end_of_message) begin
          if (eff_st != mfdo_pkg::FILL_REJECT) begin
            len_we              = 1'b1;
            len_wdata           = fill_idx_next;
            free_next[eff_slot] = 1'b0;
            if (count_next == '0) begin
              head_next = eff_slot;
            end else begin
              link_we = 1'b1;
            end
            tail_next  = eff_slot;
            count_next = count_next + CW'(1);
            push_ok    = 1'b1;
            push_drop  = (eff_st == mfdo_pkg::FILL_EVICT);
          end
          fill_st_next  = mfdo_pkg::FILL_IDLE;
          fill_idx_next = '0;
        end
      end
      mfdo_pkg::CMD_POP: begin
        if (count != '0) begin
          if (count > CW'(1)) head_next = link_rd;
          count_next      = count - CW'(1);
          free_next[head] = 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign pay_waddr = AW'(eff_slot) * AW'(SLOT_BYTES) + AW'(eff_idx);
  assign pay_raddr = AW'(pop_slot) * AW'(SLOT_BYTES) + AW'(pop_idx);

  // pop length is the stored length cut to max_len
  assign n_wide = (NW'(len_rd) < NW'(item.max_len)) ? NW'(len_rd) : NW'(item.max_len);
  assign n_pop  = n_wide[6:0];

  assign sts.pop_stream = (item.command == mfdo_pkg::CMD_POP) && (count != '0) &&
                          (n_pop != '0);
  assign sts.pop_last   = (pop_idx + 7'd1) == pop_n;
  assign sts.out_free   = !out_valid || rsp_ready;

  assign exec_emits = (item.command == mfdo_pkg::CMD_PUSH) ||
                      (item.command == mfdo_pkg::CMD_STATUS) ||
                      ((item.command == mfdo_pkg::CMD_POP) && !sts.pop_stream);
  assign out_load   = (ctl.exec && exec_emits) || ctl.pop_load;

  always_comb begin
    load_data = '0;
    if (ctl.pop_load) begin
      load_data.kind        = mfdo_pkg::KIND_POP;
      load_data.out_byte    = pay_rd;
      load_data.byte_valid  = 1'b1;
      load_data.out_last    = sts.pop_last;
      load_data.pop_len     = pop_n;
      load_data.entry_count = 5'(count);
      load_data.is_empty    = (count == '0);
    end else begin
      load_data.entry_count = 5'(count_next);
      load_data.is_empty    = (count_next == '0);
      case (item.command)
        mfdo_pkg::CMD_PUSH: begin
          load_data.kind    = mfdo_pkg::KIND_PUSH;
          load_data.push_ok = push_ok;
          load_data.dropped = push_drop;
        end
        mfdo_pkg::CMD_POP: begin
          load_data.kind     = mfdo_pkg::KIND_POP;
          load_data.out_last = 1'b1;
        end
        default: begin
          load_data.kind = mfdo_pkg::KIND_STATUS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_oldest <= 1'b0;
      free        <= '1;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      fill_st     <= mfdo_pkg::FILL_IDLE;
      fill_slot   <= '0;
      fill_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) drop_oldest <= cfg_data;
      if (ctl.exec) begin
        free      <= free_next;
        head      <= head_next;
        tail      <= tail_next;
        count     <= count_next;
        fill_st   <= fill_st_next;
        fill_slot <= fill_slot_next;
        fill_idx  <= fill_idx_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.take) item <= req_data;
    if (out_load) out_q <= load_data;
    if (ctl.exec) begin
      pop_slot <= head;
      pop_idx  <= '0;
      pop_n    <= n_pop;
    end else if (ctl.pop_load) begin
      pop_idx <= pop_idx + 7'd1;
    end
  end

  // memories, read data registered
  always_ff @(posedge clk) begin
    if (ctl.exec && pay_we) payload[pay_waddr] <= item.in_byte;
    pay_rd <= payload[pay_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && len_we) len_mem[eff_slot] <= len_wdata;
    len_rd <= len_mem[head];
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && link_we) link_mem[tail] <= eff_slot;
    link_rd <= link_mem[head];
  end

  assign rsp_valid = out_valid;
  assign rsp_data  = out_q;

endmodule

>>> rtl/message_fifo_drop_oldest_unit.sv
// top level of the message fifo with drop-oldest overflow
// depends on mfdo_pkg, mfdo_chan_if, mfdo_ctrl and mfdo_datapath
//
// request channel: one item per push byte, pop or status query. result channel:
// one item per push byte, one per status query, and for a pop one item per
// returned byte (or a single empty item when nothing is returned). cfg channel:
// writes the drop_oldest bit; it is always ready. the user must write it only while the
// block is idle; the block itself does not enforce this.
// messages live in SLOT_COUNT slots of SLOT_BYTES bytes; a new message takes
// the lowest free slot, and with the pool full either evicts the head message
// (drop_oldest set) or swallows the message and reports it not stored.
// timing: a request is taken in the idle state and executed in the exec state, which
// waits while the result register is still full. a pop then makes, for each of its
// n bytes, one payload memory read followed by a load of the result register. the
// result register frees the block from the receiver, so the next request is taken
// while the last result still waits.
// reset (rst, synchronous) empties the queue, frees every slot, drops any
// partly pushed message, clears drop_oldest and discards a pending result.
// no clearing pass is needed after reset. a stalled receiver holds the block
// at its next result load; nothing is lost.
module message_fifo_drop_oldest_unit #(
  parameter int SLOT_COUNT = 16,
  parameter int SLOT_BYTES = 64
) (
  input logic clk,
  input logic rst,
  mfdo_chan_if.sink   request,
  mfdo_chan_if.source result,
  mfdo_chan_if.sink   cfg
);

  mfdo_pkg::ctl_t ctl;
  mfdo_pkg::sts_t sts;
  logic           req_ready;

  mfdo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  mfdo_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .req_data  (request.data),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp_data  (result.data),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_data  (cfg.data)
  );

  assign request.ready = req_ready;

endmodule

>>> rtl/mfdo_checker.sv
// port-level checks on the message fifo, attached to the top level by bind
// depends on mfdo_pkg for the result type and kind codes
module mfdo_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input mfdo_pkg::rsp_t rsp
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // an accepted request is worked on before another is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one executes");

  // mid-run pop bytes keep the request side closed
  a_pop_run_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == mfdo_pkg::KIND_POP && rsp.byte_valid && !rsp.out_last
    |-> !req_ready)
    else $error("request open in the middle of a pop run");

  // reset discards a pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid straight after reset");

endmodule

bind message_fifo_drop_oldest_unit mfdo_checker u_mfdo_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .rsp_valid (result.valid),
  .rsp_ready (result.ready),
  .rsp       (result.data)
);

>>> bench/tb_message_fifo_drop_oldest_unit.sv
// bench for message_fifo_drop_oldest_unit: a directed table, then random push/pop traffic
// under both overflow modes, results checked against a model of the slot pool and queue
// (typed directed rows against their table entries); depends on mfdo_pkg, mfdo_chan_if and the rtl of the block
module tb_message_fifo_drop_oldest_unit;
  import mfdo_pkg::*;

  localparam int SLOTS = 16;
  localparam int SLOT_SIZE = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT = 1000000;
  localparam rsp_t NO_RSP = '0;

  typedef struct packed {
    req_t       req;
    logic [6:0] reps;
    logic       typed;
    rsp_t       want;
  } step_row_t;

  // reps sends the row that many times with in_byte counting up
  localparam int DIRECTED_N = 25;
  localparam int EVICT_ROW = 22;
  localparam step_row_t DIRECTED [DIRECTED_N] = '{
    '{'{CMD_STATUS, 8'h00, 1'b0, 7'd0}, 7'd1, 1'b1,
      '{KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 5'd0, 1'b1}},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd64}, 7'd1, 1'b1,
      '{KIND_POP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0, 5'd0, 1'b1}},
    '{'{CMD_UNUSED, 8'hFF, 1'b1, 7'd64}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h00, 1'b0, 7'd0}, 7'd1, 1'b1,
      '{KIND_PUSH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 5'd0, 1'b1}},
    '{'{CMD_PUSH, 8'hFF, 1'b1, 7'd64}, 7'd1, 1'b1,
      '{KIND_PUSH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 5'd1, 1'b0}},
    '{'{CMD_PUSH, 8'hA5, 1'b1, 7'd0}, 7'd1, 1'b1,
      '{KIND_PUSH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 5'd2, 1'b0}},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd64}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd0}, 7'd1, 1'b1,
      '{KIND_POP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0, 5'd0, 1'b1}},
    '{'{CMD_PUSH, 8'h33, 1'b0, 7'd0}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd64}, 7'd1, 1'b1,
      '{KIND_POP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0, 5'd0, 1'b1}},
    '{'{CMD_PUSH, 8'h44, 1'b1, 7'd0}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h10, 1'b0, 7'd0}, 7'd69, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h7F, 1'b1, 7'd0}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd64}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd64}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h55, 1'b0, 7'd0}, 7'd2, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h57, 1'b1, 7'd0}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd2}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h80, 1'b1, 7'd0}, 7'd16, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h01, 1'b0, 7'd0}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'h02, 1'b1, 7'd0}, 7'd1, 1'b1,
      '{KIND_PUSH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 5'd16, 1'b0}},
    '{'{CMD_STATUS, 8'h00, 1'b0, 7'd0}, 7'd1, 1'b1,
      '{KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 5'd16, 1'b0}},
    '{'{CMD_PUSH, 8'hC0, 1'b0, 7'd0}, 7'd1, 1'b0, NO_RSP},
    '{'{CMD_PUSH, 8'hC1, 1'b1, 7'd0}, 7'd1, 1'b1,
      '{KIND_PUSH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 7'd0, 5'd16, 1'b0}},
    '{'{CMD_POP, 8'h00, 1'b0, 7'd1}, 7'd1, 1'b0, NO_RSP}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mfdo_chan_if #(.payload_t(req_t)) req_ch ();
  mfdo_chan_if #(.payload_t(rsp_t)) rsp_ch ();
  mfdo_chan_if #(.payload_t(logic)) cfg_ch ();

  message_fifo_drop_oldest_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model of the slot pool and the linked message queue
  logic [7:0]  slot_data [SLOTS][SLOT_SIZE];
  logic [6:0]  slot_len [SLOTS];
  logic [3:0]  slot_next [SLOTS];
  logic [3:0]  oldest_slot = '0;
  logic [3:0]  newest_slot = '0;
  logic [4:0]  msg_count = '0;
  logic [3:0]  fill_slot = '0;
  logic [6:0]  fill_pos = '0;
  fill_state_t fill_mode = FILL_IDLE;
  logic        evict_mode = 1'b0;

  rsp_t step_replies [$];
  rsp_t due_replies [$];

  logic        note_typed = 1'b0;
  rsp_t        note_want = '0;
  int unsigned burst_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic rsp_t reply(input logic [1:0] kind, input logic [7:0] b, input logic v,
                                 input logic last, input logic ok, input logic drop,
                                 input logic [6:0] plen);
    rsp_t r;
    r.kind = kind;
    r.out_byte = b;
    r.byte_valid = v;
    r.out_last = last;
    r.push_ok = ok;
    r.dropped = drop;
    r.pop_len = plen;
    r.entry_count = msg_count;
    r.is_empty = (msg_count == 0);
    return r;
  endfunction

  function automatic logic [3:0] unlink_oldest();
    logic [3:0] s;
    s = oldest_slot;
    if (msg_count > 1) oldest_slot = slot_next[s];
    msg_count--;
    return s;
  endfunction

  function automatic void fifo_apply(input req_t r);
    logic [3:0] s;
    logic       found;
    logic       ok;
    logic       drop;
    logic [6:0] n;
    ok = 1'b0;
    drop = 1'b0;
    case (r.command)
      CMD_PUSH: begin
        if (fill_mode == FILL_IDLE) begin
          found = 1'b0;
          s = '0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_len[i] == 0) begin
              s = 4'(i);
              found = 1'b1;
            end
          end
          if (found) begin
            fill_mode = FILL_ACTIVE;
          end else if (evict_mode && msg_count > 0) begin
            s = unlink_oldest();
            slot_len[s] = '0;
            fill_mode = FILL_EVICT;
          end else begin
            fill_mode = FILL_REJECT;
            s = '0;
          end
          fill_slot = s;
          fill_pos = '0;
        end
        // bytes past the slot size are dropped
        if (fill_mode != FILL_REJECT && fill_pos < SLOT_SIZE) begin
          slot_data[fill_slot][fill_pos] = r.in_byte;
          fill_pos++;
        end
        if (r.end_of_message) begin
          if (fill_mode != FILL_REJECT) begin
            slot_len[fill_slot] = fill_pos;
            if (msg_count == 0) oldest_slot = fill_slot;
            else slot_next[newest_slot] = fill_slot;
            newest_slot = fill_slot;
            msg_count++;
            ok = 1'b1;
            drop = (fill_mode == FILL_EVICT);
          end
          fill_mode = FILL_IDLE;
          fill_pos = '0;
        end
        step_replies.push_back(reply(KIND_PUSH, 8'h00, 1'b0, 1'b0, ok, drop, 7'd0));
      end
      CMD_POP: begin
        if (msg_count == 0) begin
          step_replies.push_back(reply(KIND_POP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0));
        end else begin
          s = unlink_oldest();
          n = (slot_len[s] > r.max_len) ? r.max_len : slot_len[s];
          slot_len[s] = '0;
          if (n == 0) begin
            step_replies.push_back(reply(KIND_POP, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0));
          end else begin
            for (int i = 0; i < n; i++) begin
              step_replies.push_back(reply(KIND_POP, slot_data[s][i], 1'b1, (i + 1 == n),
                                           1'b0, 1'b0, n));
            end
          end
        end
      end
      CMD_STATUS: begin
        step_replies.push_back(reply(KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0));
      end
      default: ;
    endcase
  endfunction

  function automatic void show_reply(input string tag, input rsp_t r);
    $display("  %s kind=%0d byte=%h valid=%0d last=%0d ok=%0d drop=%0d len=%0d count=%0d empty=%0d",
             tag, r.kind, r.out_byte, r.byte_valid, r.out_last, r.push_ok, r.dropped,
             r.pop_len, r.entry_count, r.is_empty);
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) evict_mode = cfg_ch.data;
      if (req_ch.valid && req_ch.ready) begin
        step_replies.delete();
        fifo_apply(req_ch.data);
        if (note_typed) step_replies = '{note_want};
        foreach (step_replies[j]) due_replies.push_back(step_replies[j]);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result with nothing expected");
            show_reply("got", rsp_ch.data);
          end
        end else begin
          want = due_replies.pop_front();
          if (rsp_ch.data.kind !== want.kind || rsp_ch.data.out_byte !== want.out_byte ||
              rsp_ch.data.byte_valid !== want.byte_valid ||
              rsp_ch.data.out_last !== want.out_last || rsp_ch.data.push_ok !== want.push_ok ||
              rsp_ch.data.dropped !== want.dropped || rsp_ch.data.pop_len !== want.pop_len ||
              rsp_ch.data.entry_count !== want.entry_count ||
              rsp_ch.data.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at cycle %0d", cycles);
              show_reply("expected", want);
              show_reply("got", rsp_ch.data);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb_message_fifo_drop_oldest_unit: errors");
      $finish;
    end
  end

  // receiver: short stalls, short runs and now and then a long free stretch
  logic        sink_ready = 1'b0;
  int unsigned sink_hold = 0;
  assign rsp_ch.ready = sink_ready;

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      case ($urandom_range(0, 7))
        0: begin
          sink_ready <= 1'b1;
          sink_hold <= 48;
        end
        1, 2, 3: begin
          sink_ready <= 1'b0;
          sink_hold <= $urandom_range(0, 5);
        end
        default: begin
          sink_ready <= 1'b1;
          sink_hold <= $urandom_range(0, 6);
        end
      endcase
    end
  end

  task automatic send_req(input req_t r, input logic typed, input rsp_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    note_typed <= typed;
    note_want <= want;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // sender holds off until every expected result is in, then lets the block go quiet
  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_evict_mode(input logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [6:0] pick_max_len();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd64;
      default: return 7'($urandom_range(0, 64));
    endcase
  endfunction

  // mostly whole messages with random content, pops and queries mixed in between
  // and inside messages, plus the odd unused command
  task automatic run_traffic(input int unsigned target, input int unsigned push_pct);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    req_t        r;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < push_pct) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        for (int i = 1; i <= len; i++) begin
          if ($urandom_range(0, 11) == 0) begin
            r.command = $urandom_range(0, 1) ? CMD_POP : CMD_STATUS;
            r.in_byte = 8'($urandom_range(0, 255));
            r.end_of_message = 1'($urandom_range(0, 1));
            r.max_len = pick_max_len();
            send_req(r, 1'b0, NO_RSP);
            sent++;
          end
          r.command = CMD_PUSH;
          r.in_byte = 8'($urandom_range(0, 255));
          r.end_of_message = (i == len);
          r.max_len = 7'($urandom_range(0, 64));
          send_req(r, 1'b0, NO_RSP);
          sent++;
        end
      end else begin
        pick = $urandom_range(0, 9);
        r.in_byte = 8'($urandom_range(0, 255));
        r.end_of_message = 1'($urandom_range(0, 1));
        r.max_len = pick_max_len();
        if (pick < 6) r.command = CMD_POP;
        else if (pick < 9) r.command = CMD_STATUS;
        else r.command = CMD_UNUSED;
        send_req(r, 1'b0, NO_RSP);
        if (r.command != CMD_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    req_t r;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    for (int i = 0; i < SLOTS; i++) slot_len[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_evict_mode(1'b0);

    for (int i = 0; i < DIRECTED_N; i++) begin
      if (i == EVICT_ROW) begin
        wait_quiet();
        write_evict_mode(1'b1);
      end
      for (int k = 0; k < DIRECTED[i].reps; k++) begin
        r = DIRECTED[i].req;
        r.in_byte = r.in_byte + 8'(k);
        send_req(r, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    run_traffic(90, 65);
    wait_quiet();
    write_evict_mode(1'b0);
    run_traffic(90, 75);
    wait_quiet();
    write_evict_mode(1'b1);
    run_traffic(80, 45);
    wait_quiet();

    if (mismatches == 0 && due_replies.size() == 0) begin
      $display("tb_message_fifo_drop_oldest_unit: clean");
    end else begin
      $display("tb_message_fifo_drop_oldest_unit: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mfdo_pkg.sv
rtl/mfdo_chan_if.sv
rtl/mfdo_ctrl.sv
rtl/mfdo_datapath.sv
rtl/message_fifo_drop_oldest_unit.sv
rtl/mfdo_checker.sv
bench/tb_message_fifo_drop_oldest_unit.sv
